// ----- src/hap_pkg.sv -----
`timescale 1ns / 1ps

package hap_pkg;

	// Store geometry
	localparam int MAX_PHI       = 512;
	localparam int MAX_MOM       = 128;
	localparam int DZDR_CHANNELS = 32;
	localparam int STORE_DEPTH   = MAX_PHI * MAX_MOM * DZDR_CHANNELS;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int AW1           = ADDR_W + 1;

	// Field widths
	localparam int OP_W    = 2;
	localparam int PHI_Q_W = 16;
	localparam int SLOPE_W = 17;
	localparam int STEP_W  = 16;
	localparam int DZ_W    = 5;
	localparam int BIN_W   = 21;
	localparam int CNT_W   = 8;
	localparam int FRAC_W  = 7;
	localparam int PH_W    = 18;
	localparam int Q0_W    = PH_W - FRAC_W;

	// Configuration registers
	localparam int PHI_CFG_W = 10;
	localparam int MOM_CFG_W = 8;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PHI_BINS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MOM_BINS = 1'b1;
	localparam int PHI_RESET = 500;
	localparam int MOM_RESET = 70;

	// Clamped geometry widths
	localparam int PC_W = $clog2(MAX_PHI + 1);
	localparam int MC_W = $clog2(MAX_MOM + 1);
	localparam int TS_W = PC_W + MC_W;

	// Shared divider
	localparam int DIV_NUM_W = BIN_W;
	localparam int DIV_DEN_W = TS_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// Local maximum: three candidates per row, three rows
	localparam int LOCAL_ROW   = 3;
	localparam int LOCAL_CANDS = 3 * LOCAL_ROW;
	localparam int LK_W        = $clog2(LOCAL_CANDS);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_FILL    = 2'd1,
		OP_ANALYSE = 2'd2,
		OP_LOCAL   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_PREP,
		ST_WDIV0,
		ST_WDIV1,
		ST_WALK,
		ST_LCHK,
		ST_LDIV0,
		ST_LDIV1,
		ST_LOCAL,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
		logic [DIV_DEN_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ----- src/hap_ram.sv -----
`timescale 1ns / 1ps

module hap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/hap_div.sv -----
`timescale 1ns / 1ps

module hap_div (
	input  logic               clk,
	input  logic               arst_n,
	input  hap_pkg::div_req_t  req,
	output hap_pkg::div_rsp_t  rsp
);

	logic                               run_q;
	logic                               done_q;
	logic [hap_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [hap_pkg::DIV_NUM_W-1:0]      num_q;
	logic [hap_pkg::DIV_DEN_W-1:0]      den_q;
	logic [hap_pkg::DIV_DEN_W-1:0]      rem_q;
	logic [hap_pkg::DIV_DEN_W:0]        shifted;
	logic [hap_pkg::DIV_DEN_W:0]        trial;
	logic                               qbit;

	// Restoring step: bring down one dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, num_q[hap_pkg::DIV_NUM_W-1]};
		trial   = shifted - {1'b0, den_q};
		qbit    = ~trial[hap_pkg::DIV_DEN_W];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == hap_pkg::DIV_CNT_W'(hap_pkg::DIV_NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[hap_pkg::DIV_NUM_W-2:0], qbit};
			rem_q <= qbit ? trial[hap_pkg::DIV_DEN_W-1:0]
				: shifted[hap_pkg::DIV_DEN_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = num_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- src/hough_accumulator_peak_finder.sv -----
`timescale 1ns / 1ps

// Hough vote store (8-bit counters, slope slice x momentum row x phi bin) with peak search.
// Command channel: an item is taken at a clock edge with start high and busy low. Operations:
// clear the store, fill (one vote per momentum row), analyse (running strict maximum over the
// same bins) and local maximum (best of a bin's 3x3 neighbourhood, phi wraps, rows clip).
// Result channel: done is high for one cycle with peak_count and peak_bin; every item gives
// exactly one result (zeros for clear and fill). The receiver cannot stall; the result is
// valid only in that cycle. Configuration: cfg_valid/cfg_ready beat writes phi_bins (index 0)
// or mom_bins (index 1); write it only while the block is idle. cfg_ready is always high.
// Fill and analyse use two passes of the shared 21-step radix-2 divider (start phase and step
// reduced modulo phi_bins) and one RAM read per momentum row. Local maximum uses two divider
// passes to split the bin into row and phi, then up to nine reads. Clear writes one RAM word per
// cycle. One item is in flight at a time; busy stays high until the result beat.
// Reset: the store is swept to zero, one word per cycle, with busy high; no
// result is given for that sweep. Running maximum clears to zero, registers to 500 and 70.

module hough_accumulator_peak_finder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [hap_pkg::OP_W-1:0]       operation,
	input  logic [hap_pkg::PHI_Q_W-1:0]    phi_q,
	input  logic signed [hap_pkg::SLOPE_W-1:0] slope_q,
	input  logic [hap_pkg::STEP_W-1:0]     slope_step,
	input  logic [hap_pkg::DZ_W-1:0]       dzdr_index,
	input  logic                           new_hit,
	input  logic [hap_pkg::BIN_W-1:0]      bin_index,
	output logic                           done,
	output logic [hap_pkg::CNT_W-1:0]      peak_count,
	output logic [hap_pkg::BIN_W-1:0]      peak_bin,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hap_pkg::CFG_W-1:0]      cfg_data
);

	hap_pkg::state_t state_q, state_d;
	hap_pkg::op_t    op_q, op_in;

	logic [hap_pkg::PHI_CFG_W-1:0] phi_bins_q;
	logic [hap_pkg::MOM_CFG_W-1:0] mom_bins_q;

	logic [hap_pkg::PHI_Q_W-1:0]  fld_phi_q;
	logic [hap_pkg::SLOPE_W-1:0]  fld_slope_q;
	logic [hap_pkg::STEP_W-1:0]   fld_step_q;
	logic [hap_pkg::DZ_W-1:0]     fld_dz_q;
	logic [hap_pkg::BIN_W-1:0]    fld_bin_q;

	logic [hap_pkg::PC_W-1:0]     p_use, p_q;
	logic [hap_pkg::MC_W-1:0]     m_use, m_q;
	logic [hap_pkg::TS_W-1:0]     ts_q;

	// Walk state
	logic signed [hap_pkg::PH_W-1:0] phase0;
	logic signed [hap_pkg::Q0_W-1:0] q0;
	logic                            q0_neg;
	logic [hap_pkg::Q0_W-1:0]        q0_mag;
	logic [hap_pkg::PC_W-1:0]        div_rem_p;
	logic [hap_pkg::PC_W-1:0]        q_init;
	logic [hap_pkg::PC_W-1:0]        q_q, smod_q;
	logic [hap_pkg::PC_W:0]          q_sum;
	logic [hap_pkg::PC_W-1:0]        q_next;
	logic [hap_pkg::FRAC_W-1:0]      frac_q;
	logic [hap_pkg::FRAC_W:0]        frac_sum;
	logic [hap_pkg::AW1-1:0]         row_base_q, walk_addr;
	logic [hap_pkg::MC_W-1:0]        row_q;
	logic                            dz_out;

	// Local maximum state
	logic [31:0]                     bin_lim;
	logic                            bin_out;
	logic [hap_pkg::AW1-1:0]         bin_w, a1_q, a2_q, lbase, loc_addr, p_w;
	logic [hap_pkg::PC_W-1:0]        lf;
	logic [hap_pkg::MC_W-1:0]        lrow;
	logic                            up_q, dn_q, loc_en;
	logic [hap_pkg::LK_W-1:0]        k_q;
	logic [hap_pkg::CNT_W-1:0]       loc_max_q;
	logic [hap_pkg::AW1-1:0]         loc_bin_q;

	// Running maximum
	logic [hap_pkg::CNT_W-1:0]       run_max_q;
	logic [hap_pkg::BIN_W-1:0]       run_bin_q;

	// Memory and read pipeline
	logic                            ram_we, issue;
	logic [hap_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr, clr_addr_q, pend_addr_s1;
	logic [hap_pkg::CNT_W-1:0]       ram_wdata, rd_data, sat_inc;
	logic                            pend_s1;
	logic                            sweep_rep_q;

	logic                            done_q;
	logic [hap_pkg::CNT_W-1:0]       peak_count_q;
	logic [hap_pkg::BIN_W-1:0]       peak_bin_q;

	hap_pkg::div_req_t div_req;
	hap_pkg::div_rsp_t div_rsp;

	assign op_in     = hap_pkg::op_t'(operation);
	assign busy      = (state_q != hap_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done       = done_q;
	assign peak_count = peak_count_q;
	assign peak_bin   = peak_bin_q;

	// Register clamps
	always_comb begin
		if (32'(phi_bins_q) < 1) p_use = hap_pkg::PC_W'(1);
		else if (32'(phi_bins_q) > hap_pkg::MAX_PHI) p_use = hap_pkg::PC_W'(hap_pkg::MAX_PHI);
		else p_use = hap_pkg::PC_W'(phi_bins_q);
		if (32'(mom_bins_q) < 2) m_use = hap_pkg::MC_W'(2);
		else if (32'(mom_bins_q) > hap_pkg::MAX_MOM) m_use = hap_pkg::MC_W'(hap_pkg::MAX_MOM);
		else m_use = hap_pkg::MC_W'(mom_bins_q);
	end

	// Start phase: integer part floors, its sign handled after the modulo
	always_comb begin
		phase0 = $signed({2'b00, fld_phi_q})
			- $signed({fld_slope_q[hap_pkg::SLOPE_W-1], fld_slope_q});
		q0     = phase0[hap_pkg::PH_W-1:hap_pkg::FRAC_W];
		q0_neg = phase0[hap_pkg::PH_W-1];
		q0_mag = q0_neg ? hap_pkg::Q0_W'(-q0) : hap_pkg::Q0_W'(q0);
		div_rem_p = hap_pkg::PC_W'(div_rsp.remainder);
		if (!q0_neg) q_init = div_rem_p;
		else if (div_rem_p == '0) q_init = '0;
		else q_init = p_q - div_rem_p;
		dz_out = (32'(fld_dz_q) >= hap_pkg::DZDR_CHANNELS);
	end

	// Per-row phase step: fraction carry plus step modulo phi, one wrap
	always_comb begin
		frac_sum  = {1'b0, frac_q} + {1'b0, fld_step_q[hap_pkg::FRAC_W-1:0]};
		q_sum     = {1'b0, q_q} + {1'b0, smod_q} + (hap_pkg::PC_W+1)'(frac_sum[hap_pkg::FRAC_W]);
		q_next    = (q_sum >= {1'b0, p_q}) ? hap_pkg::PC_W'(q_sum - {1'b0, p_q})
			: hap_pkg::PC_W'(q_sum);
		walk_addr = row_base_q + hap_pkg::AW1'(q_q);
	end

	// Neighbourhood addressing
	always_comb begin
		p_w     = hap_pkg::AW1'(p_q);
		bin_w   = hap_pkg::AW1'(fld_bin_q);
		bin_lim = 32'(ts_q) * 32'(hap_pkg::DZDR_CHANNELS);
		bin_out = (32'(fld_bin_q) >= bin_lim) || (32'(fld_bin_q) >= hap_pkg::STORE_DEPTH);
		lf      = hap_pkg::PC_W'(div_rsp.remainder);
		lrow    = hap_pkg::MC_W'(div_rsp.quotient);
		case (k_q)
			hap_pkg::LK_W'(0), hap_pkg::LK_W'(3), hap_pkg::LK_W'(6): lbase = bin_w;
			hap_pkg::LK_W'(1), hap_pkg::LK_W'(4), hap_pkg::LK_W'(7): lbase = a1_q;
			default: lbase = a2_q;
		endcase
		if (32'(k_q) < hap_pkg::LOCAL_ROW) begin
			loc_addr = lbase;
			loc_en   = 1'b1;
		end else if (32'(k_q) < 2 * hap_pkg::LOCAL_ROW) begin
			loc_addr = lbase + p_w;
			loc_en   = up_q;
		end else begin
			loc_addr = lbase - p_w;
			loc_en   = dn_q;
		end
	end

	assign sat_inc = (rd_data == {hap_pkg::CNT_W{1'b1}}) ? rd_data : rd_data + 1'b1;

	// Sequencer: next state, divider requests, memory ports
	always_comb begin
		state_d   = state_q;
		div_req   = '0;
		ram_we    = pend_s1 && (op_q == hap_pkg::OP_FILL);
		ram_waddr = pend_addr_s1;
		ram_wdata = sat_inc;
		ram_raddr = hap_pkg::ADDR_W'(walk_addr);
		issue     = 1'b0;
		case (state_q)
			hap_pkg::ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == hap_pkg::ADDR_W'(hap_pkg::STORE_DEPTH - 1))
					state_d = sweep_rep_q ? hap_pkg::ST_FINISH : hap_pkg::ST_IDLE;
			end
			hap_pkg::ST_IDLE: begin
				if (start)
					state_d = (op_in == hap_pkg::OP_CLEAR) ? hap_pkg::ST_SWEEP : hap_pkg::ST_PREP;
			end
			hap_pkg::ST_PREP: begin
				if (op_q == hap_pkg::OP_LOCAL) begin
					state_d = hap_pkg::ST_LCHK;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = hap_pkg::DIV_NUM_W'(q0_mag);
					div_req.divisor  = hap_pkg::DIV_DEN_W'(p_q);
					state_d          = hap_pkg::ST_WDIV0;
				end
			end
			hap_pkg::ST_WDIV0: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = hap_pkg::DIV_NUM_W'(fld_step_q[hap_pkg::STEP_W-1:hap_pkg::FRAC_W]);
					div_req.divisor  = hap_pkg::DIV_DEN_W'(p_q);
					state_d          = hap_pkg::ST_WDIV1;
				end
			end
			hap_pkg::ST_WDIV1: begin
				if (div_rsp.done)
					state_d = dz_out ? hap_pkg::ST_FINISH : hap_pkg::ST_WALK;
			end
			hap_pkg::ST_WALK: begin
				ram_raddr = hap_pkg::ADDR_W'(walk_addr);
				issue     = (walk_addr < hap_pkg::AW1'(hap_pkg::STORE_DEPTH));
				if (row_q == m_q - 1'b1)
					state_d = hap_pkg::ST_DRAIN;
			end
			hap_pkg::ST_LCHK: begin
				if (bin_out) begin
					state_d = hap_pkg::ST_FINISH;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = fld_bin_q;
					div_req.divisor  = hap_pkg::DIV_DEN_W'(ts_q);
					state_d          = hap_pkg::ST_LDIV0;
				end
			end
			hap_pkg::ST_LDIV0: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = hap_pkg::DIV_NUM_W'(div_rsp.remainder);
					div_req.divisor  = hap_pkg::DIV_DEN_W'(p_q);
					state_d          = hap_pkg::ST_LDIV1;
				end
			end
			hap_pkg::ST_LDIV1: begin
				if (div_rsp.done)
					state_d = hap_pkg::ST_LOCAL;
			end
			hap_pkg::ST_LOCAL: begin
				ram_raddr = hap_pkg::ADDR_W'(loc_addr);
				issue     = loc_en;
				if (k_q == hap_pkg::LK_W'(hap_pkg::LOCAL_CANDS - 1))
					state_d = hap_pkg::ST_DRAIN;
			end
			hap_pkg::ST_DRAIN:  state_d = hap_pkg::ST_FINISH;
			hap_pkg::ST_FINISH: state_d = hap_pkg::ST_IDLE;
			default:            state_d = hap_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hap_pkg::ST_SWEEP;
			clr_addr_q  <= '0;
			sweep_rep_q <= 1'b0;
			pend_s1     <= 1'b0;
			done_q      <= 1'b0;
			run_max_q   <= '0;
			run_bin_q   <= '0;
			phi_bins_q  <= hap_pkg::PHI_CFG_W'(hap_pkg::PHI_RESET);
			mom_bins_q  <= hap_pkg::MOM_CFG_W'(hap_pkg::MOM_RESET);
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			done_q  <= (state_q == hap_pkg::ST_FINISH);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hap_pkg::REG_PHI_BINS: phi_bins_q <= hap_pkg::PHI_CFG_W'(cfg_data);
					hap_pkg::REG_MOM_BINS: mom_bins_q <= hap_pkg::MOM_CFG_W'(cfg_data);
					default: ;
				endcase
			end
			if (state_q == hap_pkg::ST_SWEEP)
				clr_addr_q <= clr_addr_q + 1'b1;
			if (state_q == hap_pkg::ST_IDLE && start) begin
				if (op_in == hap_pkg::OP_CLEAR) begin
					clr_addr_q  <= '0;
					sweep_rep_q <= 1'b1;
				end
				if (op_in == hap_pkg::OP_ANALYSE && new_hit) begin
					run_max_q <= '0;
					run_bin_q <= '0;
				end
			end
			// Running strict maximum over returned beats
			if (pend_s1 && op_q == hap_pkg::OP_ANALYSE && rd_data > run_max_q) begin
				run_max_q <= rd_data;
				run_bin_q <= hap_pkg::BIN_W'(pend_addr_s1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		pend_addr_s1 <= ram_raddr;
		case (state_q)
			hap_pkg::ST_IDLE: begin
				if (start) begin
					op_q        <= op_in;
					fld_phi_q   <= phi_q;
					fld_slope_q <= slope_q;
					fld_step_q  <= slope_step;
					fld_dz_q    <= dzdr_index;
					fld_bin_q   <= bin_index;
					p_q         <= p_use;
					m_q         <= m_use;
				end
			end
			hap_pkg::ST_PREP: ts_q <= hap_pkg::TS_W'(p_q) * hap_pkg::TS_W'(m_q);
			hap_pkg::ST_WDIV0: begin
				row_base_q <= hap_pkg::AW1'(fld_dz_q) * hap_pkg::AW1'(ts_q);
				row_q      <= '0;
				frac_q     <= phase0[hap_pkg::FRAC_W-1:0];
				if (div_rsp.done)
					q_q <= q_init;
			end
			hap_pkg::ST_WDIV1: begin
				if (div_rsp.done)
					smod_q <= div_rem_p;
			end
			hap_pkg::ST_WALK: begin
				frac_q     <= frac_sum[hap_pkg::FRAC_W-1:0];
				q_q        <= q_next;
				row_base_q <= row_base_q + p_w;
				row_q      <= row_q + 1'b1;
			end
			hap_pkg::ST_LCHK: begin
				loc_max_q <= '0;
				loc_bin_q <= bin_w;
				k_q       <= '0;
			end
			hap_pkg::ST_LDIV1: begin
				if (div_rsp.done) begin
					a1_q <= (lf == '0) ? bin_w - 1'b1 + p_w : bin_w - 1'b1;
					a2_q <= (lf == p_q - 1'b1) ? bin_w + 1'b1 - p_w : bin_w + 1'b1;
					up_q <= ({1'b0, lrow} + 1'b1) < {1'b0, m_q};
					dn_q <= (lrow != '0);
				end
			end
			hap_pkg::ST_LOCAL: k_q <= k_q + 1'b1;
			hap_pkg::ST_FINISH: begin
				case (op_q)
					hap_pkg::OP_ANALYSE: begin
						peak_count_q <= run_max_q;
						peak_bin_q   <= run_bin_q;
					end
					hap_pkg::OP_LOCAL: begin
						peak_count_q <= loc_max_q;
						peak_bin_q   <= hap_pkg::BIN_W'(loc_bin_q);
					end
					default: begin
						peak_count_q <= '0;
						peak_bin_q   <= '0;
					end
				endcase
			end
			default: ;
		endcase
		// Neighbourhood best, strict compare keeps the earlier candidate on ties
		if (pend_s1 && op_q == hap_pkg::OP_LOCAL && rd_data > loc_max_q) begin
			loc_max_q <= rd_data;
			loc_bin_q <= hap_pkg::AW1'(pend_addr_s1);
		end
	end

	hap_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	hap_ram #(
		.WIDTH (hap_pkg::CNT_W),
		.DEPTH (hap_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// Result beat only once the sequencer has returned to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// Read beats only come back from walk or neighbourhood scans
	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == hap_pkg::ST_WALK || state_q == hap_pkg::ST_LOCAL
			|| state_q == hap_pkg::ST_DRAIN))
		else $error("read beat outside a scan");

	// Store is never written while idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != hap_pkg::ST_IDLE)
		else $error("store write while idle");

	// Phi bin stays reduced during the walk
	a_phi_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hap_pkg::ST_WALK |-> q_q < p_q)
		else $error("phi bin out of range");

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start");

endmodule
